@@ hw/rtl/qxmm_pkg.sv @@
// Types, constants and register codes shared by the quad-X mixer files.
`default_nettype none
package qxmm_pkg;

  localparam logic [11:0] COMP_LOW = 12'd800;
  localparam logic signed [12:0] COMP_REF = 13'sd1240;

  localparam logic [11:0] RST_THROTTLE_CEILING = 12'd1850;
  localparam logic        RST_COMP_ENABLE      = 1'b1;
  localparam logic [11:0] RST_COMP_THRESHOLD   = 12'd1200;
  localparam logic [11:0] RST_RUN_MIN_PULSE    = 12'd1100;
  localparam logic [11:0] RST_RUN_MAX_PULSE    = 12'd2000;
  localparam logic [11:0] RST_KEEPALIVE_PULSE  = 12'd1000;

  typedef enum logic [2:0] {
    CFG_THROTTLE_CEILING = 3'd0,
    CFG_COMP_ENABLE      = 3'd1,
    CFG_COMP_THRESHOLD   = 3'd2,
    CFG_RUN_MIN_PULSE    = 3'd3,
    CFG_RUN_MAX_PULSE    = 3'd4,
    CFG_KEEPALIVE_PULSE  = 3'd5
  } cfg_index_t;

  typedef logic signed [14:0] mix_val_t;
  typedef logic signed [27:0] prod_val_t;
  typedef logic signed [14:0] delta_t;
  typedef logic [11:0]        pulse_t;

  // after mixing: factor is zero when compensation is off
  typedef struct packed {
    logic                fly;
    logic signed [12:0]  factor;
    mix_val_t [3:0]      m;
  } mix_item_t;

  typedef struct packed {
    logic            fly;
    mix_val_t [3:0]  m;
    prod_val_t [3:0] prod;
  } prod_item_t;

  typedef struct packed {
    logic            fly;
    mix_val_t [3:0]  m;
    delta_t [3:0]    d;
  } delta_item_t;

endpackage
`default_nettype wire

@@ hw/rtl/qxmm_ifs.sv @@
// Handshake interfaces for the command and motor channels.
`default_nettype none
interface qxmm_cmd_if;
  logic                valid;
  logic                ready;
  logic                fly_enable;
  logic [11:0]         throttle_level;
  logic [11:0]         battery_level;
  logic signed [11:0]  pitch_correction;
  logic signed [11:0]  roll_correction;
  logic signed [11:0]  yaw_correction;

  modport source (output valid, fly_enable, throttle_level, battery_level,
                  pitch_correction, roll_correction, yaw_correction,
                  input ready);
  modport sink (input valid, fly_enable, throttle_level, battery_level,
                pitch_correction, roll_correction, yaw_correction,
                output ready);
endinterface

interface qxmm_motor_if;
  logic        valid;
  logic        ready;
  logic [11:0] motor_one_pulse;
  logic [11:0] motor_two_pulse;
  logic [11:0] motor_three_pulse;
  logic [11:0] motor_four_pulse;

  modport source (output valid, motor_one_pulse, motor_two_pulse,
                  motor_three_pulse, motor_four_pulse, input ready);
  modport sink (input valid, motor_one_pulse, motor_two_pulse,
                motor_three_pulse, motor_four_pulse, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/quad_x_motor_mixer.sv @@
// Top level of the quad-X motor mixer: config registers and four-stage pipeline.
//
//   channel  dir  handshake        payload
//   cmd      in   valid / ready    fly_enable, throttle_level, battery_level,
//                                  pitch/roll/yaw_correction
//   motor    out  valid / ready    motor_one..four_pulse
//   cfg      in   cfg_we           cfg_index, cfg_data (write only)
//
// A result reaches motor through four register stages, the first loaded at
// the edge that accepts its item; one item per cycle sustained while
// motor.ready is held high. Stages: mix, multiply by factor, scale by
// 300 and shift, add and clamp into the output register.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// Each stage holds while its successor is full and stalled; bubbles are
// squeezed out, so cmd.ready drops only when all four stages are full.
`default_nettype none
module quad_x_motor_mixer (
  input  wire logic          clk,
  input  wire logic          rst,
  qxmm_cmd_if.sink           cmd,
  qxmm_motor_if.source       motor,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [11:0]   cfg_data
);

  // configuration registers
  logic [11:0] throttle_ceiling;
  logic        comp_enable;
  logic [11:0] comp_threshold;
  logic [11:0] run_min_pulse;
  logic [11:0] run_max_pulse;
  logic [11:0] keepalive_pulse;

  // pipeline links
  logic                            mix_valid, mix_ready;
  qxmm_pkg::mix_item_t             mix_item;
  logic                            cmp_valid, cmp_ready;
  qxmm_pkg::delta_item_t           cmp_item;
  qxmm_pkg::pulse_t [3:0]          pulses;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_ceiling <= qxmm_pkg::RST_THROTTLE_CEILING;
      comp_enable      <= qxmm_pkg::RST_COMP_ENABLE;
      comp_threshold   <= qxmm_pkg::RST_COMP_THRESHOLD;
      run_min_pulse    <= qxmm_pkg::RST_RUN_MIN_PULSE;
      run_max_pulse    <= qxmm_pkg::RST_RUN_MAX_PULSE;
      keepalive_pulse  <= qxmm_pkg::RST_KEEPALIVE_PULSE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qxmm_pkg::CFG_THROTTLE_CEILING: throttle_ceiling <= cfg_data;
        qxmm_pkg::CFG_COMP_ENABLE:      comp_enable      <= cfg_data[0];
        qxmm_pkg::CFG_COMP_THRESHOLD:   comp_threshold   <= cfg_data;
        qxmm_pkg::CFG_RUN_MIN_PULSE:    run_min_pulse    <= cfg_data;
        qxmm_pkg::CFG_RUN_MAX_PULSE:    run_max_pulse    <= cfg_data;
        qxmm_pkg::CFG_KEEPALIVE_PULSE:  keepalive_pulse  <= cfg_data;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // stage 1: cap, mix, factor
  qxmm_mix u_mix (
    .clk              (clk),
    .rst              (rst),
    .up_valid         (cmd.valid),
    .up_ready         (cmd.ready),
    .fly_enable       (cmd.fly_enable),
    .throttle_level   (cmd.throttle_level),
    .battery_level    (cmd.battery_level),
    .pitch_correction (cmd.pitch_correction),
    .roll_correction  (cmd.roll_correction),
    .yaw_correction   (cmd.yaw_correction),
    .throttle_ceiling (throttle_ceiling),
    .comp_enable      (comp_enable),
    .comp_threshold   (comp_threshold),
    .dn_valid         (mix_valid),
    .dn_ready         (mix_ready),
    .dn_item          (mix_item)
  );

  // stages 2 and 3: battery correction term
  qxmm_comp u_comp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_item  (mix_item),
    .dn_valid (cmp_valid),
    .dn_ready (cmp_ready),
    .dn_item  (cmp_item)
  );

  // stage 4: add, clamp, standby select; output register
  qxmm_clamp u_clamp (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (cmp_valid),
    .up_ready        (cmp_ready),
    .up_item         (cmp_item),
    .run_min_pulse   (run_min_pulse),
    .run_max_pulse   (run_max_pulse),
    .keepalive_pulse (keepalive_pulse),
    .dn_valid        (motor.valid),
    .dn_ready        (motor.ready),
    .dn_pulse        (pulses)
  );

  assign motor.motor_one_pulse   = pulses[0];
  assign motor.motor_two_pulse   = pulses[1];
  assign motor.motor_three_pulse = pulses[2];
  assign motor.motor_four_pulse  = pulses[3];

`ifndef SYNTHESIS
  // input back-pressure only when the whole pipe is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (motor.valid && !motor.ready && cmp_valid && mix_valid))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/qxmm_mix.sv @@
// Stage 1: throttle cap, quad-X mix and compensation factor.
`default_nettype none
module qxmm_mix (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire logic                 fly_enable,
  input  wire logic [11:0]          throttle_level,
  input  wire logic [11:0]          battery_level,
  input  wire logic signed [11:0]   pitch_correction,
  input  wire logic signed [11:0]   roll_correction,
  input  wire logic signed [11:0]   yaw_correction,
  input  wire logic [11:0]          throttle_ceiling,
  input  wire logic                 comp_enable,
  input  wire logic [11:0]          comp_threshold,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output qxmm_pkg::mix_item_t       dn_item
);

  logic                  en;
  logic [11:0]           t;
  qxmm_pkg::mix_val_t    te, pe, re, ye;
  logic                  comp_on;
  qxmm_pkg::mix_item_t   item_next;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_comb begin
    t  = (throttle_level > throttle_ceiling) ? throttle_ceiling : throttle_level;
    te = qxmm_pkg::mix_val_t'({3'b000, t});
    pe = qxmm_pkg::mix_val_t'({{3{pitch_correction[11]}}, pitch_correction});
    re = qxmm_pkg::mix_val_t'({{3{roll_correction[11]}}, roll_correction});
    ye = qxmm_pkg::mix_val_t'({{3{yaw_correction[11]}}, yaw_correction});
    comp_on = comp_enable && (battery_level < comp_threshold)
              && (battery_level > qxmm_pkg::COMP_LOW);
    item_next.fly    = fly_enable;
    item_next.factor = comp_on ? (qxmm_pkg::COMP_REF - $signed({1'b0, battery_level}))
                               : 13'sd0;
    item_next.m[0] = te - pe + re - ye;
    item_next.m[1] = te + pe + re + ye;
    item_next.m[2] = te + pe - re - ye;
    item_next.m[3] = te - pe - re + ye;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/qxmm_comp.sv @@
// Stages 2 and 3: compensation product, then scale by 300 and shift.
`default_nettype none
module qxmm_comp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire qxmm_pkg::mix_item_t  up_item,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output qxmm_pkg::delta_item_t     dn_item
);

  logic                   en2, en3;
  logic                   v2;
  qxmm_pkg::prod_item_t   s2;
  qxmm_pkg::prod_val_t    prod_c [4];
  logic signed [36:0]     px [4];
  logic signed [36:0]     p300 [4];
  logic [36:0]            mag [4];
  logic [13:0]            q [4];
  qxmm_pkg::delta_item_t  d_next;

  assign en3      = !dn_valid || dn_ready;
  assign en2      = !v2 || en3;
  assign up_ready = en2;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod_c[k] = $signed(up_item.m[k]) * $signed(up_item.factor);
    end
  end

  // x*300 = x*256 + x*32 + x*8 + x*4, then magnitude >> 20 (truncate to zero)
  always_comb begin
    d_next.fly = s2.fly;
    d_next.m   = s2.m;
    for (int k = 0; k < 4; k++) begin
      px[k]   = {{9{s2.prod[k][27]}}, s2.prod[k]};
      p300[k] = (px[k] <<< 8) + (px[k] <<< 5) + (px[k] <<< 3) + (px[k] <<< 2);
      mag[k]  = p300[k][36] ? 37'(-p300[k]) : 37'(p300[k]);
      q[k]    = mag[k][33:20];
      d_next.d[k] = p300[k][36] ? -$signed({1'b0, q[k]}) : $signed({1'b0, q[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (en2) v2 <= up_valid;
      if (en3) dn_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && up_valid) begin
      s2.fly <= up_item.fly;
      s2.m   <= up_item.m;
      for (int k = 0; k < 4; k++) begin
        s2.prod[k] <= prod_c[k];
      end
    end
    if (en3 && v2) begin
      dn_item <= d_next;
    end
  end

`ifndef SYNTHESIS
  // a zero product must give a zero correction
  a_zero_prod: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && s2.prod[0] == '0 && s2.prod[3] == '0)
      |=> (dn_item.d[0] == '0 && dn_item.d[3] == '0))
    else $error("zero product gave non-zero correction");
  // correction sign never opposes the product sign
  a_sign: assert property (@(posedge clk) disable iff (rst)
    (en3 && v2 && !s2.prod[1][27]) |=> !dn_item.d[1][14])
    else $error("correction sign flipped");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/qxmm_clamp.sv @@
// Stage 4: add correction, clamp to running range, select keepalive.
`default_nettype none
module qxmm_clamp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   up_valid,
  output logic                        up_ready,
  input  wire qxmm_pkg::delta_item_t  up_item,
  input  wire logic [11:0]            run_min_pulse,
  input  wire logic [11:0]            run_max_pulse,
  input  wire logic [11:0]            keepalive_pulse,
  output logic                        dn_valid,
  input  wire logic                   dn_ready,
  output qxmm_pkg::pulse_t [3:0]      dn_pulse
);

  logic                     en;
  logic signed [15:0]       sum [4];
  logic signed [15:0]       lo, hi;
  qxmm_pkg::pulse_t [3:0]   pulse_next;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_comb begin
    lo = $signed({4'b0000, run_min_pulse});
    hi = $signed({4'b0000, run_max_pulse});
    for (int k = 0; k < 4; k++) begin
      sum[k] = $signed({up_item.m[k][14], up_item.m[k]})
               + $signed({up_item.d[k][14], up_item.d[k]});
      if (!up_item.fly) begin
        pulse_next[k] = keepalive_pulse;
      end else if (sum[k] < lo) begin
        pulse_next[k] = run_min_pulse;
      end else if (sum[k] > hi) begin
        pulse_next[k] = run_max_pulse;
      end else begin
        pulse_next[k] = sum[k][11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      dn_pulse <= pulse_next;
    end
  end

`ifndef SYNTHESIS
  // flying output stays inside an ordered running range
  a_range: assert property (@(posedge clk) disable iff (rst)
    (en && up_valid && up_item.fly && run_min_pulse <= run_max_pulse)
      |=> (dn_pulse[0] >= run_min_pulse && dn_pulse[0] <= run_max_pulse
           && dn_pulse[2] >= run_min_pulse && dn_pulse[2] <= run_max_pulse))
    else $error("motor pulse outside running range");
`endif

endmodule
`default_nettype wire
